// ----- design/tpd_pkg.sv -----
package tpd_pkg;

  // Configuration register indexes
  localparam logic [2:0] CFG_NEW_FORMAT    = 3'd0;
  localparam logic [2:0] CFG_EXTENDED_CAPS = 3'd1;
  localparam logic [2:0] CFG_FOUR_BUTTONS  = 3'd2;
  localparam logic [2:0] CFG_MULTI_FINGER  = 3'd3;
  localparam logic [2:0] CFG_PALM_DETECT   = 3'd4;
  localparam logic [2:0] CFG_EXTRA_COUNT   = 3'd5;
  localparam logic [2:0] CFG_RESYNC_LIMIT  = 3'd6;

  // Byte positions within a packet
  localparam logic [2:0] BYTE_FIRST  = 3'd0;
  localparam logic [2:0] BYTE_SECOND = 3'd1;
  localparam logic [2:0] BYTE_FOURTH = 3'd3;
  localparam logic [2:0] BYTE_FIFTH  = 3'd4;
  localparam logic [2:0] BYTE_LAST   = 3'd5;

  // Sync patterns
  localparam logic [7:0] NEW_MASK      = 8'hC8;
  localparam logic [7:0] NEW_HEAD_SYNC = 8'h80;
  localparam logic [7:0] NEW_MID_SYNC  = 8'hC0;
  localparam logic [7:0] OLD_MASK      = 8'hC0;
  localparam logic [7:0] OLD_HEAD_SYNC = 8'hC0;
  localparam logic [7:0] OLD_MID_SYNC  = 8'h80;
  localparam logic [7:0] OLD_ZERO_MASK = 8'h60;

  localparam logic [7:0]  LOSS_MAX    = 8'd255;
  localparam logic [13:0] Y_FLIP_BASE = 14'(4448 + 1408);
  localparam logic [7:0]  TOUCH_ON    = 8'd30;
  localparam logic [7:0]  TOUCH_OFF   = 8'd25;
  localparam logic [3:0]  WIDTH_DEFAULT = 4'd5;
  localparam logic [3:0]  WIDTH_PALM_MIN = 4'd4;
  localparam logic [3:0]  EXTRA_MIN   = 4'd2;
  localparam logic [3:0]  EXTRA_MAX   = 4'd8;

  // Queue between front and back
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [1:0] {
    KIND_TOUCH      = 2'd0,
    KIND_LOST       = 2'd1,
    KIND_LOST_LIMIT = 2'd2
  } kind_t;

  typedef struct packed {
    logic       new_format;
    logic       extended_caps;
    logic       four_buttons;
    logic       multi_finger;
    logic       palm_detect;
    logic [3:0] extra_button_count;
    logic [7:0] resync_limit;
  } cfg_t;

  typedef struct packed {
    logic            lost;
    logic            limit;
    logic [5:0][7:0] bytes;
  } job_t;

endpackage

// ----- design/touchpad_packet_decoder_top.sv -----
// Channel  | Handshake                  | Payload
// ---------+----------------------------+------------------------------------------
// input    | byte_valid / byte_stall    | data_byte
// result   | result_valid / result_stall| kind, positions, pressure, buttons, ...
// config   | cfg_write                  | cfg_index, cfg_data
//
// One byte is taken every cycle while byte_stall is low. A result is written to the
// queue at the edge that takes its last byte (or bad sync byte), moves to the output
// register when that register is free, and waits there while result_stall is high.
// A two-word queue separates byte checking from decoding; byte_stall rises only
// when that queue is full. Reset is synchronous and clears the byte position,
// loss count, touch bit, queue and configuration to their reset values.
module touchpad_packet_decoder_top
  import tpd_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_write,
  input  logic [2:0]         cfg_index,
  input  logic [7:0]         cfg_data,
  input  logic               byte_valid,
  output logic               byte_stall,
  input  logic [7:0]         data_byte,
  output logic               result_valid,
  input  logic               result_stall,
  output logic [1:0]         kind,
  output logic               position_valid,
  output logic [12:0]        x_position,
  output logic signed [13:0] y_position,
  output logic [7:0]         pressure,
  output logic               touching,
  output logic [3:0]         tool_width,
  output logic [1:0]         finger_count,
  output logic [3:0]         main_buttons,
  output logic [7:0]         extra_buttons,
  output logic               extra_valid
);

  cfg_t cfg;
  logic push;
  job_t push_job;
  logic full;
  logic empty;
  logic pop;
  job_t head;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.new_format         <= 1'b1;
      cfg.extended_caps      <= 1'b0;
      cfg.four_buttons       <= 1'b0;
      cfg.multi_finger       <= 1'b0;
      cfg.palm_detect        <= 1'b0;
      cfg.extra_button_count <= 4'd0;
      cfg.resync_limit       <= 8'd0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        CFG_NEW_FORMAT:    cfg.new_format         <= cfg_data[0];
        CFG_EXTENDED_CAPS: cfg.extended_caps      <= cfg_data[0];
        CFG_FOUR_BUTTONS:  cfg.four_buttons       <= cfg_data[0];
        CFG_MULTI_FINGER:  cfg.multi_finger       <= cfg_data[0];
        CFG_PALM_DETECT:   cfg.palm_detect        <= cfg_data[0];
        CFG_EXTRA_COUNT:   cfg.extra_button_count <= cfg_data[3:0];
        CFG_RESYNC_LIMIT:  cfg.resync_limit       <= cfg_data;
        default: ;
      endcase
    end
  end

  tpd_front u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .byte_valid (byte_valid),
    .byte_stall (byte_stall),
    .data_byte  (data_byte),
    .queue_full (full),
    .push       (push),
    .push_job   (push_job)
  );

  tpd_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_job (push_job),
    .full     (full),
    .pop      (pop),
    .empty    (empty),
    .head     (head)
  );

  tpd_back u_back (
    .clk            (clk),
    .rst            (rst),
    .cfg            (cfg),
    .empty          (empty),
    .head           (head),
    .pop            (pop),
    .result_valid   (result_valid),
    .result_stall   (result_stall),
    .kind           (kind),
    .position_valid (position_valid),
    .x_position     (x_position),
    .y_position     (y_position),
    .pressure       (pressure),
    .touching       (touching),
    .tool_width     (tool_width),
    .finger_count   (finger_count),
    .main_buttons   (main_buttons),
    .extra_buttons  (extra_buttons),
    .extra_valid    (extra_valid)
  );

endmodule

// ----- design/tpd_front.sv -----
module tpd_front
  import tpd_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  cfg_t       cfg,
  input  logic       byte_valid,
  output logic       byte_stall,
  input  logic [7:0] data_byte,
  input  logic       queue_full,
  output logic       push,
  output job_t       push_job
);

  logic [2:0]      byte_index;
  logic [2:0]      byte_index_next;
  logic [4:0][7:0] pkt;
  logic [7:0]      loss_count;
  logic [7:0]      loss_count_next;
  logic            accept;
  logic            bad;
  logic            limit_hit;

  assign byte_stall = queue_full;
  assign accept     = byte_valid && !queue_full;

  always_comb begin
    bad = 1'b0;
    unique case (byte_index)
      BYTE_FIRST: begin
        bad = cfg.new_format ? ((data_byte & NEW_MASK) != NEW_HEAD_SYNC)
                             : ((data_byte & OLD_MASK) != OLD_HEAD_SYNC);
      end
      BYTE_SECOND, BYTE_FIFTH: begin
        bad = !cfg.new_format && ((data_byte & OLD_ZERO_MASK) != 8'd0);
      end
      BYTE_FOURTH: begin
        bad = cfg.new_format ? ((data_byte & NEW_MASK) != NEW_MID_SYNC)
                             : ((data_byte & OLD_MASK) != OLD_MID_SYNC);
      end
      default: bad = 1'b0;
    endcase
  end

  always_comb begin
    loss_count_next = loss_count;
    byte_index_next = byte_index;
    limit_hit       = 1'b0;
    if (bad) begin
      byte_index_next = BYTE_FIRST;
      if (loss_count != LOSS_MAX) begin
        loss_count_next = loss_count + 8'd1;
        limit_hit = (cfg.resync_limit != 8'd0) && (loss_count_next == cfg.resync_limit);
      end
    end else if (byte_index == BYTE_LAST) begin
      byte_index_next = BYTE_FIRST;
      loss_count_next = 8'd0;
    end else begin
      byte_index_next = byte_index + 3'd1;
    end
  end

  assign push           = accept && (bad || byte_index == BYTE_LAST);
  assign push_job.lost  = bad;
  assign push_job.limit = limit_hit;
  assign push_job.bytes = {data_byte, pkt};

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_index <= BYTE_FIRST;
      loss_count <= 8'd0;
    end else if (accept) begin
      byte_index <= byte_index_next;
      loss_count <= loss_count_next;
    end
  end

  // store bytes one to five until the packet completes
  always_ff @(posedge clk) begin
    if (accept && !bad && byte_index != BYTE_LAST) begin
      pkt[byte_index] <= data_byte;
    end
  end

endmodule

// ----- design/tpd_queue.sv -----
module tpd_queue
  import tpd_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  job_t push_job,
  output logic full,
  input  logic pop,
  output logic empty,
  output job_t head
);

  job_t              mem [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;

  assign full  = (count == QCNT_W'(QUEUE_DEPTH));
  assign empty = (count == '0);
  assign head  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + QPTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + QCNT_W'(1);
      end else if (pop && !push) begin
        count <= count - QCNT_W'(1);
      end
    end
  end

endmodule

// ----- design/tpd_back.sv -----
module tpd_back
  import tpd_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  cfg_t               cfg,
  input  logic               empty,
  input  job_t               head,
  output logic               pop,
  output logic               result_valid,
  input  logic               result_stall,
  output logic [1:0]         kind,
  output logic               position_valid,
  output logic [12:0]        x_position,
  output logic signed [13:0] y_position,
  output logic [7:0]         pressure,
  output logic               touching,
  output logic [3:0]         tool_width,
  output logic [1:0]         finger_count,
  output logic [3:0]         main_buttons,
  output logic [7:0]         extra_buttons,
  output logic               extra_valid
);

  logic       touch_state;
  logic       touch_next;
  logic [7:0] b0, b1, b2, b3, b4, b5;
  logic [12:0] x, y;
  logic [7:0]  z;
  logic [3:0]  w;
  logic        left, right, up, down;
  logic [7:0]  extra;
  logic [3:0]  nx;
  logic        nx_ok;
  logic [3:0]  width;
  logic [1:0]  fingers;

  assign pop = !empty && (!result_valid || !result_stall);

  assign b0 = head.bytes[0];
  assign b1 = head.bytes[1];
  assign b2 = head.bytes[2];
  assign b3 = head.bytes[3];
  assign b4 = head.bytes[4];
  assign b5 = head.bytes[5];

  assign nx    = cfg.extra_button_count & 4'hE;
  assign nx_ok = (nx >= EXTRA_MIN) && (nx <= EXTRA_MAX);

  always_comb begin
    up    = 1'b0;
    down  = 1'b0;
    extra = 8'd0;
    left  = b0[0];
    right = b0[1];
    if (cfg.new_format) begin
      x = {b3[4], b1[3:0], b4};
      y = {b3[5], b1[7:4], b5};
      z = b2;
      w = {b0[5:4], b0[2], b3[2]};
      if (cfg.extended_caps && cfg.four_buttons) begin
        up   = b3[0] ^ left;
        down = b3[1] ^ right;
      end
      if (nx_ok && (b3[1] != right)) begin
        for (int i = 0; i < 4; i++) begin
          if (4'(2 * i) < nx) begin
            extra[2*i]   = b4[i];
            extra[2*i+1] = b5[i];
          end
        end
      end
    end else begin
      x = {b1[4:0], b2};
      y = {b4[4:0], b5};
      z = {b0[5:4], b3[5:0]};
      w = {b1[7], 1'b0, b0[2], 1'b0};
    end
  end

  always_comb begin
    fingers = 2'd0;
    width   = 4'd0;
    if (z != 8'd0) begin
      fingers = 2'd1;
      width   = WIDTH_DEFAULT;
      if (cfg.extended_caps) begin
        if (w <= 4'd1 && cfg.multi_finger) fingers = w[1:0] + 2'd2;
        if (w >= WIDTH_PALM_MIN && cfg.palm_detect) width = w;
      end
    end
  end

  // hysteresis: set above the on level, clear below the off level, else hold
  always_comb begin
    touch_next = touch_state;
    if (z > TOUCH_ON) touch_next = 1'b1;
    if (z < TOUCH_OFF) touch_next = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
      touch_state  <= 1'b0;
    end else begin
      if (pop) begin
        result_valid <= 1'b1;
        if (!head.lost) touch_state <= touch_next;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      if (head.lost) begin
        kind           <= head.limit ? KIND_LOST_LIMIT : KIND_LOST;
        position_valid <= 1'b0;
        x_position     <= 13'd0;
        y_position     <= 14'sd0;
        pressure       <= 8'd0;
        touching       <= 1'b0;
        tool_width     <= 4'd0;
        finger_count   <= 2'd0;
        main_buttons   <= 4'd0;
        extra_buttons  <= 8'd0;
        extra_valid    <= 1'b0;
      end else begin
        kind           <= KIND_TOUCH;
        position_valid <= (z != 8'd0);
        x_position     <= (z != 8'd0) ? x : 13'd0;
        y_position     <= (z != 8'd0) ? signed'(Y_FLIP_BASE - {1'b0, y}) : 14'sd0;
        pressure       <= z;
        touching       <= touch_next;
        tool_width     <= width;
        finger_count   <= fingers;
        main_buttons   <= {down, up, right, left};
        extra_buttons  <= extra;
        extra_valid    <= nx_ok;
      end
    end
  end

endmodule

// ----- tb/touchpad_packet_decoder_top_test.sv -----
module touchpad_packet_decoder_top_test;
  import tpd_pkg::*;

  localparam logic [2:0] BYTE_THIRD = 3'd2;
  localparam int PHASE_ITEMS = 145;
  localparam int SATURATE_ITEMS = 270;
  localparam int unsigned CYCLE_LIMIT = 400000;

  typedef struct packed {
    kind_t              kind;
    logic               position_valid;
    logic [12:0]        x;
    logic signed [13:0] y;
    logic [7:0]         z;
    logic               touching;
    logic [3:0]         width;
    logic [1:0]         fingers;
    logic [3:0]         buttons;
    logic [7:0]         extra;
    logic               extra_valid;
  } report_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               cfg_write = 1'b0;
  logic [2:0]         cfg_index = '0;
  logic [7:0]         cfg_data = '0;
  logic               byte_valid = 1'b0;
  logic               byte_stall;
  logic [7:0]         data_byte = '0;
  logic               result_valid;
  logic               result_stall = 1'b0;
  logic [1:0]         kind;
  logic               position_valid;
  logic [12:0]        x_position;
  logic signed [13:0] y_position;
  logic [7:0]         pressure;
  logic               touching;
  logic [3:0]         tool_width;
  logic [1:0]         finger_count;
  logic [3:0]         main_buttons;
  logic [7:0]         extra_buttons;
  logic               extra_valid;

  // Decoder state as the testbench sees it
  cfg_t       cfg_model;
  logic [2:0] pkt_pos;
  logic [7:0] held [5];
  logic [7:0] loss_count;
  logic       touch_state;

  report_t     reports_due [$];
  int          mismatch_count = 0;
  int          src_idle_pct = 0;
  int          sink_stall_pct = 0;
  int          sink_hold_cycles = 0;
  int          stall_left = 0;
  int unsigned cycle_count = 0;

  touchpad_packet_decoder_top DUT (
    .clk(clk), .rst(rst),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .byte_valid(byte_valid), .byte_stall(byte_stall), .data_byte(data_byte),
    .result_valid(result_valid), .result_stall(result_stall),
    .kind(kind), .position_valid(position_valid),
    .x_position(x_position), .y_position(y_position),
    .pressure(pressure), .touching(touching), .tool_width(tool_width),
    .finger_count(finger_count), .main_buttons(main_buttons),
    .extra_buttons(extra_buttons), .extra_valid(extra_valid)
  );

  initial forever #1 clk = ~clk;

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // Mostly short runs, now and then a long one
  function automatic int run_length();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 70) return $urandom_range(1, 2);
    if (roll < 92) return $urandom_range(3, 6);
    return $urandom_range(10, 25);
  endfunction

  function automatic int idle_share();
    case ($urandom_range(0, 3))
      0: return 0;
      1: return 10;
      2: return 30;
      default: return 60;
    endcase
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      result_stall <= 1'b0;
    end else if (sink_hold_cycles > 0) begin
      result_stall <= 1'b1;
      sink_hold_cycles = sink_hold_cycles - 1;
    end else if (stall_left > 0) begin
      stall_left = stall_left - 1;
    end else if ($urandom_range(0, 99) < sink_stall_pct) begin
      result_stall <= 1'b1;
      stall_left = run_length() - 1;
    end else begin
      result_stall <= 1'b0;
    end
  end

  function automatic logic sync_ok(input logic [2:0] pos, input logic [7:0] d);
    case (pos)
      BYTE_FIRST:
        return cfg_model.new_format ? (d & NEW_MASK) == NEW_HEAD_SYNC
                                    : (d & OLD_MASK) == OLD_HEAD_SYNC;
      BYTE_SECOND, BYTE_FIFTH:
        return cfg_model.new_format || (d & OLD_ZERO_MASK) == 8'h00;
      BYTE_FOURTH:
        return cfg_model.new_format ? (d & NEW_MASK) == NEW_MID_SYNC
                                    : (d & OLD_MASK) == OLD_MID_SYNC;
      default:
        return 1'b1;
    endcase
  endfunction

  // Pressure values biased toward zero and the touch thresholds
  function automatic logic [7:0] pick_pressure();
    case ($urandom_range(0, 3))
      0: return 8'd0;
      1, 2: return 8'($urandom_range(20, 35));
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic logic [7:0] sync_byte(input logic [2:0] pos);
    logic [7:0] d;
    d = 8'($urandom_range(0, 255));
    if (cfg_model.new_format) begin
      case (pos)
        BYTE_FIRST: d = (d & ~NEW_MASK) | NEW_HEAD_SYNC;
        BYTE_THIRD: d = pick_pressure();
        BYTE_FOURTH: d = (d & ~NEW_MASK) | NEW_MID_SYNC;
        default: ;
      endcase
    end else begin
      case (pos)
        BYTE_FIRST: begin
          d = (d & ~OLD_MASK) | OLD_HEAD_SYNC;
          if ($urandom_range(0, 1) == 0) d[5:4] = 2'b00;
        end
        BYTE_SECOND, BYTE_FIFTH: d = d & ~OLD_ZERO_MASK;
        BYTE_FOURTH: begin
          d = (d & ~OLD_MASK) | OLD_MID_SYNC;
          if ($urandom_range(0, 1) == 0) d = (d & 8'hC0) | (pick_pressure() & 8'h3F);
        end
        default: ;
      endcase
    end
    return d;
  endfunction

  function automatic logic [7:0] broken_byte(input logic [2:0] pos);
    logic [7:0] d;
    do d = 8'($urandom_range(0, 255)); while (sync_ok(pos, d));
    return d;
  endfunction

  // Mostly the next word of a good packet, some sync breaks, a little noise
  function automatic logic [7:0] stim_byte();
    int unsigned roll;
    logic        breakable;
    roll = $urandom_range(0, 99);
    breakable = pkt_pos == BYTE_FIRST || pkt_pos == BYTE_FOURTH ||
                (!cfg_model.new_format && (pkt_pos == BYTE_SECOND || pkt_pos == BYTE_FIFTH));
    if (roll < 3) return 8'($urandom_range(0, 255));
    if (roll < 7 && breakable) return broken_byte(pkt_pos);
    return sync_byte(pkt_pos);
  endfunction

  // Advance the packet state by one accepted word and queue any report it causes
  task automatic track_byte(input logic [7:0] d);
    report_t     r;
    logic [7:0]  b [6];
    logic [12:0] x, y;
    logic [7:0]  z;
    logic [3:0]  w, nx;
    logic        left, right, up, down, hit;
    int          i;
    r = '0;
    if (!sync_ok(pkt_pos, d)) begin
      pkt_pos = BYTE_FIRST;
      hit = 1'b0;
      if (loss_count != LOSS_MAX) begin
        loss_count++;
        hit = cfg_model.resync_limit != 8'd0 && loss_count == cfg_model.resync_limit;
      end
      r.kind = hit ? KIND_LOST_LIMIT : KIND_LOST;
      reports_due.push_back(r);
    end else if (pkt_pos != BYTE_LAST) begin
      held[pkt_pos] = d;
      pkt_pos++;
    end else begin
      for (i = 0; i < 5; i++) b[i] = held[i];
      b[5] = d;
      left = b[0][0];
      right = b[0][1];
      up = 1'b0;
      down = 1'b0;
      nx = cfg_model.extra_button_count & 4'hE;
      if (nx < EXTRA_MIN || nx > EXTRA_MAX) nx = 4'd0;
      if (cfg_model.new_format) begin
        x = {b[3][4], b[1][3:0], b[4]};
        y = {b[3][5], b[1][7:4], b[5]};
        z = b[2];
        w = {b[0][5:4], b[0][2], b[3][2]};
        if (cfg_model.extended_caps && cfg_model.four_buttons) begin
          up = b[3][0] ^ left;
          down = b[3][1] ^ right;
        end
        if (nx != 4'd0 && b[3][1] != right) begin
          for (i = 0; i < nx / 2; i++) begin
            r.extra[2 * i] = b[4][i];
            r.extra[2 * i + 1] = b[5][i];
          end
        end
      end else begin
        x = {b[1][4:0], b[2]};
        y = {b[4][4:0], b[5]};
        z = {b[0][5:4], b[3][5:0]};
        w = {b[1][7], 1'b0, b[0][2], 1'b0};
      end
      if (z != 8'd0) begin
        r.position_valid = 1'b1;
        r.x = x;
        r.y = Y_FLIP_BASE - {1'b0, y};
        r.fingers = 2'd1;
        r.width = WIDTH_DEFAULT;
        if (cfg_model.extended_caps) begin
          if (w <= 4'd1 && cfg_model.multi_finger) r.fingers = 2'(w + 4'd2);
          if (w >= WIDTH_PALM_MIN && cfg_model.palm_detect) r.width = w;
        end
      end
      if (z > TOUCH_ON) touch_state = 1'b1;
      if (z < TOUCH_OFF) touch_state = 1'b0;
      r.kind = KIND_TOUCH;
      r.z = z;
      r.touching = touch_state;
      r.buttons = {down, up, right, left};
      r.extra_valid = nx != 4'd0;
      reports_due.push_back(r);
      pkt_pos = BYTE_FIRST;
      loss_count = 8'd0;
    end
  endtask

  task automatic send_byte(input logic [7:0] d);
    int idle;
    idle = ($urandom_range(0, 99) < src_idle_pct) ? run_length() : 0;
    if (idle != 0) begin
      byte_valid <= 1'b0;
      repeat (idle) @(posedge clk);
    end
    byte_valid <= 1'b1;
    data_byte <= d;
    do @(posedge clk); while (byte_stall);
    track_byte(d);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [7:0] value);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
  endtask

  // Drain every pending report, let the pipe settle, then write all registers
  task automatic apply_settings(input cfg_t c);
    byte_valid <= 1'b0;
    while (reports_due.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    write_reg(CFG_NEW_FORMAT, 8'(c.new_format));
    write_reg(CFG_EXTENDED_CAPS, 8'(c.extended_caps));
    write_reg(CFG_FOUR_BUTTONS, 8'(c.four_buttons));
    write_reg(CFG_MULTI_FINGER, 8'(c.multi_finger));
    write_reg(CFG_PALM_DETECT, 8'(c.palm_detect));
    write_reg(CFG_EXTRA_COUNT, 8'(c.extra_button_count));
    write_reg(CFG_RESYNC_LIMIT, c.resync_limit);
    cfg_write <= 1'b0;
    cfg_model = c;
  endtask

  task automatic note_failure(input string msg);
    mismatch_count++;
    if (mismatch_count <= 10) $display("%s", msg);
  endtask

  task automatic check_field(input string name, input int want, input int got);
    if (want != got) note_failure($sformatf("%s: expected %0d, got %0d", name, want, got));
  endtask

  always @(posedge clk) begin
    report_t want;
    if (!rst && result_valid && !result_stall) begin
      if (reports_due.size() == 0) begin
        note_failure($sformatf("unexpected report word, kind %0d", kind));
      end else begin
        want = reports_due.pop_front();
        check_field("kind", int'(want.kind), int'(kind));
        check_field("position_valid", want.position_valid, position_valid);
        check_field("x_position", want.x, x_position);
        check_field("y_position", int'(want.y), int'(y_position));
        check_field("pressure", want.z, pressure);
        check_field("touching", want.touching, touching);
        check_field("tool_width", want.width, tool_width);
        check_field("finger_count", want.fingers, finger_count);
        check_field("main_buttons", want.buttons, main_buttons);
        check_field("extra_buttons", want.extra, extra_buttons);
        check_field("extra_valid", want.extra_valid, extra_valid);
      end
    end
  end

  // Field extremes in both layouts, z = 0, and sync breaks at the first, second and fourth bytes
  task automatic test_directed();
    cfg_t       c;
    logic [7:0] new_words [$];
    logic [7:0] old_words [$];
    new_words = '{8'hB7, 8'hFF, 8'hFF, 8'hF7, 8'hFF, 8'hFF,
                  8'h80, 8'h00, 8'h00, 8'hC0, 8'h00, 8'h00,
                  8'h00,
                  8'h80, 8'h00, 8'h10, 8'h00};
    old_words = '{8'hFF, 8'h9F, 8'hFF, 8'hBF, 8'h9F, 8'hFF,
                  8'hC0, 8'h60};
    c = '{new_format: 1'b1, extended_caps: 1'b1, four_buttons: 1'b1,
          multi_finger: 1'b1, palm_detect: 1'b1, extra_button_count: 4'd8,
          resync_limit: 8'd3};
    src_idle_pct = 20;
    sink_stall_pct = 20;
    apply_settings(c);
    foreach (new_words[i]) send_byte(new_words[i]);
    c.new_format = 1'b0;
    apply_settings(c);
    foreach (old_words[i]) send_byte(old_words[i]);
  endtask

  // Back-to-back sync losses past 255 while the result side holds off
  task automatic test_loss_saturation();
    cfg_t c;
    c = '{new_format: 1'b1, extended_caps: 1'($urandom_range(0, 1)),
          four_buttons: 1'($urandom_range(0, 1)), multi_finger: 1'($urandom_range(0, 1)),
          palm_detect: 1'($urandom_range(0, 1)), extra_button_count: 4'($urandom_range(0, 15)),
          resync_limit: LOSS_MAX};
    apply_settings(c);
    src_idle_pct = 0;
    sink_stall_pct = 10;
    sink_hold_cycles = 150;
    // the directed part leaves the packet position at the first word
    repeat (SATURATE_ITEMS) send_byte(broken_byte(BYTE_FIRST));
  endtask

  task automatic run_phase(input cfg_t c);
    apply_settings(c);
    src_idle_pct = idle_share();
    sink_stall_pct = idle_share();
    repeat (PHASE_ITEMS) send_byte(stim_byte());
  endtask

  task automatic test_register_extremes();
    run_phase('{new_format: 1'b1, extended_caps: 1'b1, four_buttons: 1'b1,
                multi_finger: 1'b1, palm_detect: 1'b1, extra_button_count: 4'hF,
                resync_limit: 8'hFF});
    run_phase('{new_format: 1'b0, extended_caps: 1'b0, four_buttons: 1'b0,
                multi_finger: 1'b0, palm_detect: 1'b0, extra_button_count: 4'h0,
                resync_limit: 8'h00});
  endtask

  task automatic test_random_settings();
    cfg_t c;
    repeat (6) begin
      c.new_format = 1'($urandom_range(0, 1));
      c.extended_caps = $urandom_range(0, 3) != 0;
      c.four_buttons = 1'($urandom_range(0, 1));
      c.multi_finger = 1'($urandom_range(0, 1));
      c.palm_detect = 1'($urandom_range(0, 1));
      c.extra_button_count = 4'($urandom_range(0, 15));
      case ($urandom_range(0, 3))
        0: c.resync_limit = 8'd0;
        1: c.resync_limit = 8'($urandom_range(1, 4));
        2: c.resync_limit = LOSS_MAX;
        default: c.resync_limit = 8'($urandom_range(0, 255));
      endcase
      run_phase(c);
    end
  endtask

  initial begin
    cfg_model = '0;
    cfg_model.new_format = 1'b1;
    pkt_pos = BYTE_FIRST;
    loss_count = 8'd0;
    touch_state = 1'b0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    test_directed();
    test_loss_saturation();
    test_register_extremes();
    test_random_settings();
    byte_valid <= 1'b0;
    while (reports_due.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
design/tpd_pkg.sv
design/tpd_front.sv
design/tpd_queue.sv
design/tpd_back.sv
design/touchpad_packet_decoder_top.sv
tb/touchpad_packet_decoder_top_test.sv
